[src/tcw_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the console writer.
package tcw_pkg;

    localparam int MAX_COLUMNS_DEF = 80;
    localparam int MAX_ROWS_DEF    = 25;
    localparam int TAB_SPACES_DEF  = 4;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int REG_IDX_W  = 2;
    localparam int REG_DATA_W = 8;

    localparam logic [COL_W-1:0]  COLS_RST = 7'd80;
    localparam logic [ROW_W-1:0]  ROWS_RST = 5'd25;
    localparam logic [ATTR_W-1:0] ATTR_RST = 8'h0F;

    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 2'd2;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_PUT_START = 4'd2,
        OP_NEWLINE   = 4'd3,
        OP_WRITE     = 4'd4,
        OP_SCROLL    = 4'd5,
        OP_FLUSH     = 4'd6,
        OP_ZERO      = 4'd7,
        OP_CLEAR     = 4'd8,
        OP_EMIT      = 4'd9
    } op_t;

    typedef struct packed {
        logic is_put;
        logic is_read;
        logic is_clear;
        logic is_lf;
        logic is_cr;
        logic col_at_end;
        logic col_next_end;
        logic row_last;
        logic rows_one;
        logic cnt_last;
        logic sweep_last;
        logic scroll_last;
        logic zero_last;
        logic out_busy;
    } dp_status_t;

endpackage

[src/text_console_writer_unit.sv]
`timescale 1ns / 1ps
// Top level of the text console writer: stream ports, register port, controller and datapath.
//
//  port group   dir  content
//  s_axis_*     in   command items: cmd, character, read position
//  m_axis_*     out  one result item per command: cell, cursor column, cursor row
//  wr_*         in   register writes: column_count, row_count, text_attribute
//
//  A tab writes TAB_SPACES spaces and wraps at the row end as needed.
//  A scroll copies each cell in use up one row, one read and one write per copied cell on
//  the screen RAM, then clears the bottom row (only the clear on a one-row screen).
//  Reset and the clear command sweep all MAX_ROWS * MAX_COLUMNS cells (2000 by default)
//  one per cycle; no item is taken during the sweep after reset.
//  A new item is taken while the previous result waits in the output register;
//  the next result then waits until that one is taken.
module text_console_writer_unit #(
    parameter int MAX_COLUMNS = tcw_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcw_pkg::MAX_ROWS_DEF,
    parameter int TAB_SPACES  = tcw_pkg::TAB_SPACES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,  // char_code, read_col, read_row
    input  logic [tcw_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // cell_value, cursor_col, cursor_row
    input  logic                               wr_en,
    input  logic [tcw_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [tcw_pkg::REG_DATA_W-1:0]     wr_data
);

    tcw_pkg::op_t               op;
    tcw_pkg::dp_status_t        status;
    logic [tcw_pkg::CELL_W-1:0] out_cell;
    logic [tcw_pkg::COL_W-1:0]  out_col;
    logic [tcw_pkg::ROW_W-1:0]  out_row;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .op       (op),
        .status   (status)
    );

    tcw_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_SPACES  (TAB_SPACES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_cmd    (s_axis_tuser),
        .in_char   (s_axis_tdata[7:0]),
        .in_col    (s_axis_tdata[14:8]),
        .in_row    (s_axis_tdata[19:15]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cell  (out_cell),
        .out_col   (out_col),
        .out_row   (out_row)
    );

    assign m_axis_tdata = {4'b0000, out_row, out_col, out_cell};

endmodule

[src/tcw_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration, cursor, screen memory, scroll and clear counters, result register.
module tcw_datapath #(
    parameter int MAX_COLUMNS = tcw_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcw_pkg::MAX_ROWS_DEF,
    parameter int TAB_SPACES  = tcw_pkg::TAB_SPACES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcw_pkg::op_t                       op,
    output tcw_pkg::dp_status_t                status,
    input  logic                               wr_en,
    input  logic [tcw_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [tcw_pkg::REG_DATA_W-1:0]     wr_data,
    input  logic [tcw_pkg::CMD_W-1:0]          in_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]         in_char,
    input  logic [tcw_pkg::COL_W-1:0]          in_col,
    input  logic [tcw_pkg::ROW_W-1:0]          in_row,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tcw_pkg::CELL_W-1:0]         out_cell,
    output logic [tcw_pkg::COL_W-1:0]          out_col,
    output logic [tcw_pkg::ROW_W-1:0]          out_row
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(TAB_SPACES + 1);
    localparam int CW    = tcw_pkg::COL_W;
    localparam int RW    = tcw_pkg::ROW_W;

    // configuration
    logic [CW-1:0]             column_count_reg;
    logic [RW-1:0]             row_count_reg;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg;

    // cursor and sequencing counters
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    sx_reg, sx_next;
    logic [RW-1:0]    sy_reg, sy_next;
    logic [AW-1:0]    sweep_reg, sweep_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    // item payload and memory data
    tcw_pkg::cmd_t              cmd_reg;
    logic [tcw_pkg::CHAR_W-1:0] char_reg;
    logic [CW-1:0]              rcol_reg;
    logic [RW-1:0]              rrow_reg;
    logic [AW-1:0]              pend_addr_reg;
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;
    logic [tcw_pkg::CELL_W-1:0] out_cell_reg;
    logic [CW-1:0]              out_col_reg;
    logic [RW-1:0]              out_row_reg;

    logic [tcw_pkg::CELL_W-1:0] screen_mem [DEPTH];

    logic [CW-1:0]              cols;
    logic [RW-1:0]              rows;
    logic                       is_tab;
    logic                       read_in_range;
    logic [tcw_pkg::CHAR_W-1:0] write_byte;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [AW-1:0]              mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_COLUMNS) + AW'(c));
    endfunction

    // clamp counts to the usable range
    always_comb
    begin
        if (column_count_reg == '0)
            cols = CW'(1);
        else if (32'(column_count_reg) > MAX_COLUMNS)
            cols = CW'(MAX_COLUMNS);
        else
            cols = column_count_reg;

        if (row_count_reg == '0)
            rows = RW'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows = RW'(MAX_ROWS);
        else
            rows = row_count_reg;
    end

    assign is_tab        = (char_reg == tcw_pkg::CH_TAB);
    assign write_byte    = is_tab ? tcw_pkg::CH_SPACE : char_reg;
    assign read_in_range = (rrow_reg < rows) && (rcol_reg < cols);

    always_comb
    begin
        status.is_put       = (cmd_reg == tcw_pkg::CMD_PUT);
        status.is_read      = (cmd_reg == tcw_pkg::CMD_READ);
        status.is_clear     = (cmd_reg == tcw_pkg::CMD_CLEAR);
        status.is_lf        = (char_reg == tcw_pkg::CH_LF);
        status.is_cr        = (char_reg == tcw_pkg::CH_CR);
        status.col_at_end   = (col_reg >= cols);
        status.col_next_end = (({1'b0, col_reg} + 8'd1) >= {1'b0, cols});
        status.row_last     = (({1'b0, row_reg} + 6'd1) >= {1'b0, rows});
        status.rows_one     = (rows == RW'(1));
        status.cnt_last     = (cnt_reg == CNT_W'(1));
        status.sweep_last   = (sweep_reg == AW'(DEPTH - 1));
        status.scroll_last  = (({1'b0, sy_reg} + 6'd1) >= {1'b0, rows})
                              && (({1'b0, sx_reg} + 8'd1) >= {1'b0, cols});
        status.zero_last    = (({1'b0, sx_reg} + 8'd1) >= {1'b0, cols});
        status.out_busy     = out_valid_reg && !out_ready;
    end

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = '0;
        case (op)
            tcw_pkg::OP_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(row_reg, col_reg);
                mem_wdata = {attr_reg, write_byte};
            end
            tcw_pkg::OP_SCROLL, tcw_pkg::OP_FLUSH:
            begin
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = rdata_reg;
            end
            tcw_pkg::OP_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(rows - RW'(1), sx_reg);
            end
            tcw_pkg::OP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr = (op == tcw_pkg::OP_SCROLL) ? cell_addr(sy_reg, sx_reg)
                                                  : cell_addr(rrow_reg, rcol_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= screen_mem[mem_raddr];
    end

    // control state next values
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sweep_next     = sweep_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (op)
            tcw_pkg::OP_PUT_START:
            begin
                if (row_reg >= rows)
                    row_next = rows - RW'(1);
                if (status.is_lf || status.is_cr)
                    col_next = '0;
                cnt_next = is_tab ? CNT_W'(TAB_SPACES) : CNT_W'(1);
            end
            tcw_pkg::OP_NEWLINE:
            begin
                col_next = '0;
                sx_next  = '0;
                sy_next  = RW'(1);
                if (!status.row_last)
                    row_next = row_reg + RW'(1);
            end
            tcw_pkg::OP_WRITE:
            begin
                col_next = col_reg + CW'(1);
                cnt_next = cnt_reg - CNT_W'(1);
            end
            tcw_pkg::OP_SCROLL:
            begin
                pend_next = 1'b1;
                if (({1'b0, sx_reg} + 8'd1) >= {1'b0, cols})
                begin
                    sx_next = '0;
                    sy_next = sy_reg + RW'(1);
                end
                else
                begin
                    sx_next = sx_reg + CW'(1);
                end
            end
            tcw_pkg::OP_FLUSH:
            begin
                sx_next = '0;
            end
            tcw_pkg::OP_ZERO:
            begin
                sx_next = sx_reg + CW'(1);
            end
            tcw_pkg::OP_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    sweep_next = '0;
                    col_next   = '0;
                    row_next   = '0;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            tcw_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= tcw_pkg::COLS_RST;
            row_count_reg    <= tcw_pkg::ROWS_RST;
            attr_reg         <= tcw_pkg::ATTR_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            cnt_reg          <= '0;
            sx_reg           <= '0;
            sy_reg           <= '0;
            sweep_reg        <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    tcw_pkg::REG_COLUMN_COUNT:   column_count_reg <= wr_data[CW-1:0];
                    tcw_pkg::REG_ROW_COUNT:      row_count_reg    <= wr_data[RW-1:0];
                    tcw_pkg::REG_TEXT_ATTRIBUTE: attr_reg         <= wr_data;
                    default:                     attr_reg         <= attr_reg;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (op == tcw_pkg::OP_LOAD)
        begin
            cmd_reg  <= tcw_pkg::cmd_t'(in_cmd);
            char_reg <= in_char;
            rcol_reg <= in_col;
            rrow_reg <= in_row;
        end
        if (op == tcw_pkg::OP_SCROLL)
            pend_addr_reg <= cell_addr(sy_reg - RW'(1), sx_reg);
        if (op == tcw_pkg::OP_EMIT)
        begin
            out_cell_reg <= (status.is_read && read_in_range) ? rdata_reg : '0;
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cell  = out_cell_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        op == tcw_pkg::OP_EMIT |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while held");

    a_write_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        op == tcw_pkg::OP_WRITE |-> col_reg < cols)
        else $error("cell written past the columns in use");

    a_scroll_rows: assert property (@(posedge clk) disable iff (!rst_n)
        op == tcw_pkg::OP_SCROLL |-> (sy_reg != '0) && (sy_reg < rows))
        else $error("scroll source row out of range");

    a_pend_after_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(op == tcw_pkg::OP_SCROLL))
        else $error("pending copy without a scroll read");

    a_zero_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        op == tcw_pkg::OP_ZERO |-> ({1'b0, row_reg} + 6'd1) == {1'b0, rows})
        else $error("bottom row clear while cursor not on last row");

endmodule

[src/tcw_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences put, newline, scroll, clear and result hand-off.
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output tcw_pkg::op_t        op,
    input  tcw_pkg::dp_status_t status
);

    typedef enum logic [7:0] {
        S_SWEEP   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DECODE  = 8'b0000_0100,
        S_WRITE   = 8'b0000_1000,
        S_NEWLINE = 8'b0001_0000,
        S_SCROLL  = 8'b0010_0000,
        S_ZERO    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ret_write_reg, ret_write_next;
    logic   emit_reg, emit_next;
    logic   flush_reg, flush_next;

    always_comb
    begin
        state_next     = state_reg;
        ret_write_next = ret_write_reg;
        emit_next      = emit_reg;
        flush_next     = 1'b0;
        in_ready       = 1'b0;
        op             = tcw_pkg::OP_NOP;
        case (state_reg)
            S_SWEEP:
            begin
                op = tcw_pkg::OP_CLEAR;
                if (status.sweep_last)
                    state_next = emit_reg ? S_DONE : S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = tcw_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_put)
                begin
                    op = tcw_pkg::OP_PUT_START;
                    if (status.is_lf)
                    begin
                        ret_write_next = 1'b0;
                        state_next     = S_NEWLINE;
                    end
                    else if (status.is_cr)
                        state_next = S_DONE;
                    else
                        state_next = S_WRITE;
                end
                else if (status.is_clear)
                begin
                    emit_next  = 1'b1;
                    state_next = S_SWEEP;
                end
                else
                begin
                    // read data arrives from the memory during this cycle
                    state_next = S_DONE;
                end
            end
            S_WRITE:
            begin
                if (status.col_at_end)
                begin
                    // wrap before writing when the row shrank under the cursor
                    ret_write_next = 1'b1;
                    state_next     = S_NEWLINE;
                end
                else
                begin
                    op = tcw_pkg::OP_WRITE;
                    if (status.col_next_end)
                    begin
                        ret_write_next = !status.cnt_last;
                        state_next     = S_NEWLINE;
                    end
                    else if (status.cnt_last)
                        state_next = S_DONE;
                end
            end
            S_NEWLINE:
            begin
                op = tcw_pkg::OP_NEWLINE;
                if (!status.row_last)
                    state_next = ret_write_reg ? S_WRITE : S_DONE;
                else if (status.rows_one)
                    state_next = S_ZERO;
                else
                    state_next = S_SCROLL;
            end
            S_SCROLL:
            begin
                if (flush_reg)
                begin
                    // write the last copied cell
                    op         = tcw_pkg::OP_FLUSH;
                    state_next = S_ZERO;
                end
                else
                begin
                    op = tcw_pkg::OP_SCROLL;
                    if (status.scroll_last)
                        flush_next = 1'b1;
                end
            end
            S_ZERO:
            begin
                op = tcw_pkg::OP_ZERO;
                if (status.zero_last)
                    state_next = ret_write_reg ? S_WRITE : S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    op         = tcw_pkg::OP_EMIT;
                    emit_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            ret_write_reg <= 1'b0;
            emit_reg      <= 1'b0;
            flush_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_write_reg <= ret_write_next;
            emit_reg      <= emit_next;
            flush_reg     <= flush_next;
        end
    end

endmodule

[verif/text_console_writer_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking stream test of the console writer: directed and random commands against a model.
module text_console_writer_unit_test;
    import tcw_pkg::*;

    localparam int  NCOLS       = MAX_COLUMNS_DEF;
    localparam int  NROWS       = MAX_ROWS_DEF;
    localparam int  CYCLE_LIMIT = 40_000_000;
    localparam int  PHASES      = 12;
    localparam int  PHASE_ITEMS = 96;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } console_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;   // char_code, read_col, read_row
    logic [CMD_W-1:0]      s_axis_tuser;   // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // cell_value, cursor_col, cursor_row
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_index;
    logic [REG_DATA_W-1:0] wr_data;

    // console model state
    logic [CELL_W-1:0] screen_copy [0:NROWS-1][0:NCOLS-1];
    int unsigned       cur_col;
    int unsigned       cur_line;
    logic [COL_W-1:0]  cfg_cols;
    logic [ROW_W-1:0]  cfg_rows;
    logic [ATTR_W-1:0] cfg_attr;

    console_result_t   pending_results[$];
    int                error_count;
    int                stall_odds;
    longint            cycle_count;

    text_console_writer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned cols_live();
        int unsigned c;
        c = cfg_cols;
        if (c == 0) c = 1;
        if (c > NCOLS) c = NCOLS;
        return c;
    endfunction

    function automatic int unsigned rows_live();
        int unsigned r;
        r = cfg_rows;
        if (r == 0) r = 1;
        if (r > NROWS) r = NROWS;
        return r;
    endfunction

    function automatic void wipe_screen();
        for (int y = 0; y < NROWS; y++)
            for (int x = 0; x < NCOLS; x++)
                screen_copy[y][x] = '0;
        cur_col  = 0;
        cur_line = 0;
    endfunction

    // Only the columns in use scroll; cells to their right stay put.
    function automatic void advance_line();
        int unsigned rows;
        int unsigned cols;
        rows = rows_live();
        cols = cols_live();
        cur_line++;
        if (cur_line >= rows)
        begin
            for (int y = 1; y < rows; y++)
                for (int x = 0; x < cols; x++)
                    screen_copy[y-1][x] = screen_copy[y][x];
            for (int x = 0; x < cols; x++)
                screen_copy[rows-1][x] = '0;
            cur_line = rows - 1;
        end
    endfunction

    function automatic void place_cell(input logic [CHAR_W-1:0] ch);
        int unsigned cols;
        cols = cols_live();
        if (cur_col >= cols)
        begin
            cur_col = 0;
            advance_line();
        end
        screen_copy[cur_line][cur_col] = {cfg_attr, ch};
        cur_col++;
        if (cur_col >= cols)
        begin
            cur_col = 0;
            advance_line();
        end
    endfunction

    function automatic console_result_t apply_command(input cmd_t c, input logic [CHAR_W-1:0] ch,
                                                      input logic [COL_W-1:0] rc,
                                                      input logic [ROW_W-1:0] rr);
        console_result_t res;
        res.cell_value = '0;
        case (c)
            CMD_PUT:
            begin
                if (cur_line >= rows_live()) cur_line = rows_live() - 1;
                case (ch)
                    CH_LF:
                    begin
                        cur_col = 0;
                        advance_line();
                    end
                    CH_TAB:  repeat (TAB_SPACES_DEF) place_cell(CH_SPACE);
                    CH_CR:   cur_col = 0;
                    default: place_cell(ch);
                endcase
            end
            CMD_READ:
                if (rr < rows_live() && rc < cols_live())
                    res.cell_value = screen_copy[rr][rc];
            CMD_CLEAR: wipe_screen();
            default: ;
        endcase
        res.col = cur_col[COL_W-1:0];
        res.row = cur_line[ROW_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        console_result_t exp_res;
        console_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[22:16], m_axis_tdata[27:23]};
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got.cell_value !== exp_res.cell_value)
                begin
                    $error("cell_value expected %h got %h", exp_res.cell_value, got.cell_value);
                    error_count++;
                end
                if (got.col !== exp_res.col)
                begin
                    $error("cursor_col expected %0d got %0d", exp_res.col, got.col);
                    error_count++;
                end
                if (got.row !== exp_res.row)
                begin
                    $error("cursor_row expected %0d got %0d", exp_res.row, got.row);
                    error_count++;
                end
            end
        end
    end

    // Result side back-pressure in random bursts.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    task automatic send_command(input cmd_t c, input logic [CHAR_W-1:0] ch,
                                input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
        @(negedge clk);
        if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_axis_tuser  = c;
        s_axis_tdata  = {4'b0, rr, rc, ch};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(apply_command(c, ch, rc, rr));
    endtask

    // Drop valid, wait for every result, then let the block settle.
    task automatic drain_stream();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [REG_DATA_W-1:0] value);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = value;
        @(negedge clk);
        wr_en = 1'b0;
        case (idx)
            REG_COLUMN_COUNT:   cfg_cols = value[COL_W-1:0];
            REG_ROW_COUNT:      cfg_rows = value[ROW_W-1:0];
            REG_TEXT_ATTRIBUTE: cfg_attr = value[ATTR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [COL_W-1:0] cols, input logic [ROW_W-1:0] rows,
                                input logic [ATTR_W-1:0] attr);
        drain_stream();
        write_register(REG_COLUMN_COUNT, {1'($urandom_range(0, 1)), cols});
        write_register(REG_ROW_COUNT, {3'($urandom_range(0, 7)), rows});
        write_register(REG_TEXT_ATTRIBUTE, attr);
    endtask

    task automatic test_put_and_read();
        send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
        send_command(CMD_PUT, 8'h41, 7'd0, 5'd0);
        send_command(CMD_PUT, 8'hFF, 7'd127, 5'd31);
        send_command(CMD_PUT, 8'h00, 7'd0, 5'd0);
        send_command(CMD_PUT, 8'h80, 7'd0, 5'd0);
        send_command(CMD_PUT, CH_TAB, 7'd0, 5'd0);
        send_command(CMD_PUT, CH_CR, 7'd0, 5'd0);
        send_command(CMD_PUT, CH_LF, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd1, 5'd0);
        send_command(CMD_READ, 8'hFF, 7'd4, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd79, 5'd24);
        send_command(CMD_READ, 8'h00, 7'd80, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd25);
        send_command(CMD_READ, 8'h00, 7'd127, 5'd31);
        send_command(CMD_NOP, 8'hFF, 7'd127, 5'd31);
    endtask

    // A count of zero acts as one, above the maximum as the maximum.
    task automatic test_count_extremes();
        set_geometry(7'd0, 5'd0, 8'hFF);
        send_command(CMD_PUT, 8'h78, 7'd0, 5'd0);
        send_command(CMD_PUT, CH_TAB, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd1, 5'd0);
        set_geometry(7'd127, 5'd31, 8'h00);
        send_command(CMD_PUT, 8'h7A, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd1);
    endtask

    task automatic test_clear();
        send_command(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd1);
    endtask

    task automatic send_random_command();
        int               pick;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0] rc;
        logic [ROW_W-1:0] rr;
        pick = $urandom_range(0, 199);
        ch   = $urandom_range(0, 255);
        rc   = $urandom_range(0, 127);
        rr   = $urandom_range(0, 31);
        if (pick < 16)
            send_command(CMD_PUT, CH_LF, rc, rr);
        else if (pick < 28)
            send_command(CMD_PUT, CH_TAB, rc, rr);
        else if (pick < 36)
            send_command(CMD_PUT, CH_CR, rc, rr);
        else if (pick < 130)
            send_command(CMD_PUT, ch, rc, rr);
        else if (pick < 188)
        begin
            // mostly aim reads at the area in use so they hit written cells
            if ($urandom_range(0, 3) != 0)
            begin
                rc = $urandom_range(0, cols_live() - 1);
                rr = $urandom_range(0, rows_live() - 1);
            end
            send_command(CMD_READ, ch, rc, rr);
        end
        else if (pick < 198)
            send_command(CMD_NOP, ch, rc, rr);
        else
            send_command(CMD_CLEAR, ch, rc, rr);
    endtask

    // Geometry changes without a clear, so the cursor often lands outside a shrunken area.
    task automatic test_random_traffic();
        logic [COL_W-1:0]  cols;
        logic [ROW_W-1:0]  rows;
        logic [ATTR_W-1:0] attr;
        for (int p = 0; p < PHASES; p++)
        begin
            cols = $urandom_range(1, 12);
            rows = $urandom_range(1, 6);
            attr = $urandom_range(0, 255);
            case (p)
                1:
                begin
                    cols = 7'd1;
                    rows = 5'd1;
                    attr = 8'h00;
                end
                2: attr = 8'hFF;
                3:
                begin
                    cols = 7'd80;
                    rows = 5'd25;
                end
                4:
                begin
                    cols = $urandom_range(20, 40);
                    rows = $urandom_range(5, 10);
                end
                6:
                begin
                    cols = 7'd0;
                    rows = 5'd0;
                end
                9:
                begin
                    cols = 7'd127;
                    rows = 5'd31;
                end
                default: ;
            endcase
            set_geometry(cols, rows, attr);
            if (p >= PHASES - 2)
                stall_odds = 0;
            else if (p == 5)
                stall_odds = 0;
            else
                stall_odds = (p % 2 == 0) ? 3 : 8;
            repeat (PHASE_ITEMS) send_random_command();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PUT;
        m_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_COLUMN_COUNT;
        wr_data       = '0;
        error_count   = 0;
        cycle_count   = 0;
        stall_odds    = 5;
        cfg_cols      = COLS_RST;
        cfg_rows      = ROWS_RST;
        cfg_attr      = ATTR_RST;
        wipe_screen();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_put_and_read();
        test_count_extremes();
        test_clear();
        test_random_traffic();

        drain_stream();
        repeat (32) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[text_console_writer_unit.f]
src/tcw_pkg.sv
src/tcw_datapath.sv
src/tcw_ctrl.sv
src/text_console_writer_unit.sv
verif/text_console_writer_unit_test.sv
